// ----- design/uss_pkg.sv -----
// uss_pkg: shared types, constants and helpers of the UTF-8 sequence scrubber.
// No dependencies; used by every other design file except uss_if.
`default_nettype none

package uss_pkg;

  // Byte class masks and match values
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContVal   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;

  // Hold buffer and group sizes
  localparam int HoldDepth = 3;
  localparam int GrpLanes  = 4;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  // One group of results caused by a single input item
  typedef struct packed {
    logic [GrpLanes-1:0][7:0] bytes;    // lane 0 is released first
    logic [1:0]               last_idx; // index of the final lane
    logic                     present;  // 0 for a bare end marker
    logic                     eos;      // string ends on the final lane
  } grp_t;

  // Sequence length announced by a lead byte, 0 when not a lead byte
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if ((c & Lead2Mask) == Lead2Val) begin
      len = 3'd2;
    end else if ((c & Lead3Mask) == Lead3Val) begin
      len = 3'd3;
    end else if ((c & Lead4Mask) == Lead4Val) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- design/uss_if.sv -----
// uss_if: valid/ready channel interfaces for the scrubber's input and result items.
// No dependencies.
`default_nettype none

interface uss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface uss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       end_of_string;

  modport source (output valid, output out_byte, output byte_present,
                  output end_of_string, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input end_of_string, output ready);
endinterface

`default_nettype wire

// ----- design/utf8_sequence_scrubber.sv -----
// utf8_sequence_scrubber: top level of the UTF-8 scrubber.
// Depends on uss_pkg, uss_if, uss_front, uss_queue and uss_back.
//
// Usage:
//   in_ch  (sink)   takes one string byte per item, last_byte marks its end.
//   out_ch (source) gives one kept byte per item; a string that keeps no
//                   byte on its final input gets a bare end marker
//                   (byte_present 0). end_of_string flags the final item.
// Path: the first result of an input item goes into the group queue when
// the item is accepted, then into the output register, from which it can
// be taken. A multibyte sequence takes the same path after its final
// continuation byte, then follows at one byte per cycle unless held.
// Throughput: one input item and one result item per cycle unless stalled;
// the back half drains a group of up to four results at one per cycle,
// while a four-entry group queue lets the front keep accepting meanwhile.
// in_ch.ready drops only when that queue is full.
// Reset (rst_n low, synchronous) empties the queue and output register and
// drops any held sequence. When out_ch.ready is low the output item holds,
// the queue fills and then in_ch.ready falls; nothing is lost.
`default_nettype none

module utf8_sequence_scrubber (
  input  wire logic clk,
  input  wire logic rst_n,
  uss_in_if.sink    in_ch,
  uss_out_if.source out_ch
);
  import uss_pkg::*;

  grp_t grp;
  grp_t head_grp;
  logic grp_push;
  logic q_full;
  logic head_valid;
  logic pop;

  uss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .grp      (grp),
    .grp_push (grp_push)
  );

  uss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (grp_push),
    .push_grp   (grp),
    .full       (q_full),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop)
  );

  uss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- design/uss_front.sv -----
// uss_front: accepts input items, tracks the held UTF-8 sequence and builds result groups.
// Depends on uss_pkg and uss_in_if.
`default_nettype none

module uss_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  uss_in_if.sink           in_ch,
  input  wire logic        q_full,
  output uss_pkg::grp_t    grp,
  output logic             grp_push
);
  import uss_pkg::*;

  logic [2:0] exp_r, exp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] held_r   [HoldDepth];
  logic [7:0] held_nxt [HoldDepth];

  logic       accept;
  logic [7:0] c;
  logic       is_cont;
  logic       consumed;
  logic       emit_seq;
  logic [2:0] n;
  logic [2:0] len;
  logic [2:0] cnt_inc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign is_cont     = (c & ContMask) == ContVal;
  assign len         = lead_len(c);
  assign cnt_inc     = {1'b0, cnt_r} + 3'd1;

  // Classify the byte against the held sequence
  always_comb begin
    consumed = 1'b0;
    emit_seq = 1'b0;
    n        = 3'd0;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    for (int i = 0; i < HoldDepth; i++) begin
      held_nxt[i] = held_r[i];
    end

    if (exp_r != 3'd0) begin
      if (is_cont) begin
        consumed = 1'b1;
        if (cnt_inc >= exp_r) begin
          // sequence complete: release held bytes plus this one
          emit_seq = 1'b1;
          n        = cnt_inc;
          exp_nxt  = 3'd0;
          cnt_nxt  = 2'd0;
        end else if (cnt_r < 2'd3) begin
          held_nxt[cnt_r] = c;
          cnt_nxt         = cnt_inc[1:0];
        end else begin
          exp_nxt = 3'd0;
          cnt_nxt = 2'd0;
        end
      end else begin
        // broken sequence: drop what is held, handle byte afresh
        exp_nxt = 3'd0;
        cnt_nxt = 2'd0;
      end
    end

    if (!consumed) begin
      if (!c[7]) begin
        n = 3'd1;
      end else if (len != 3'd0) begin
        held_nxt[0] = c;
        cnt_nxt     = 2'd1;
        exp_nxt     = len;
      end
    end

    // end of string always drops any partial sequence
    if (in_ch.last_byte) begin
      exp_nxt = 3'd0;
      cnt_nxt = 2'd0;
    end
  end

  // Assemble the result group
  always_comb begin
    for (int i = 0; i < HoldDepth; i++) begin
      grp.bytes[i] = (emit_seq && (i < int'(cnt_r))) ? held_r[i] : c;
    end
    grp.bytes[GrpLanes-1] = c;
    grp.present  = n != 3'd0;
    grp.last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    grp.eos      = in_ch.last_byte;
    if (n == 3'd0) begin
      grp.bytes[0] = 8'd0;
    end
    grp_push = accept && ((n != 3'd0) || in_ch.last_byte);
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 3'd0;
      cnt_r <= 2'd0;
    end else if (accept) begin
      exp_r <= exp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HoldDepth; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/uss_queue.sv -----
// uss_queue: small FIFO of result groups between the front and back halves.
// Depends on uss_pkg.
`default_nettype none

module uss_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire uss_pkg::grp_t push_grp,
  output logic             full,
  output logic             head_valid,
  output uss_pkg::grp_t    head_grp,
  input  wire logic        pop
);
  import uss_pkg::*;

  grp_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = count_r == QCntW'(QDepth);
  assign head_valid = count_r != '0;
  assign head_grp   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/uss_back.sv -----
// uss_back: serializes queued result groups into single result items.
// Depends on uss_pkg and uss_out_if.
`default_nettype none

module uss_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire uss_pkg::grp_t head_grp,
  output logic             pop,
  uss_out_if.source        out_ch
);
  import uss_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_present_r;
  logic       out_eos_r;
  logic       load;
  logic       at_last;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.byte_present  = out_present_r;
  assign out_ch.end_of_string = out_eos_r;

  // Output register is free or being emptied this cycle
  assign load    = !out_valid_r || out_ch.ready;
  assign at_last = idx_r == head_grp.last_idx;
  assign pop     = load && head_valid && at_last;

  // Lane index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= at_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte_r    <= head_grp.bytes[idx_r];
      out_present_r <= head_grp.present;
      out_eos_r     <= head_grp.eos && at_last;
    end
  end

endmodule

`default_nettype wire
